@@ design/srtf_pkg.sv @@
// Shared types and constants for the SRTF scheduler.
// Holds the transaction structs, status codes and controller states.
// No dependencies.
package srtf_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 16;
    localparam int DEFAULT_TIME_WIDTH  = 16;

    localparam int JOB_W    = 8;
    localparam int FIELD_W  = 16;
    localparam int BURST_W  = 16;
    localparam int ORDER_W  = 16;
    localparam int LAST_W   = JOB_W + 1;

    localparam logic [LAST_W-1:0] NONE_RUNNING = 9'h100;

    localparam logic KIND_ARRIVE = 1'b0;
    localparam logic KIND_TICK   = 1'b1;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_FULL       = 2'd1,
        STATUS_ZERO_BURST = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_SCAN,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    typedef struct packed {
        logic               kind;
        logic [JOB_W-1:0]   job_id;
        logic [FIELD_W-1:0] arrival_time;
        logic [BURST_W-1:0] burst_length;
    } req_item_t;

    typedef struct packed {
        logic [1:0]         status;
        logic               ran_valid;
        logic [JOB_W-1:0]   ran_id;
        logic               switched;
        logic               finished;
        logic [FIELD_W-1:0] finish_time;
        logic [FIELD_W-1:0] now_time;
    } rsp_item_t;

    typedef struct packed {
        logic clear;
        logic sample;
    } pick_ctrl_t;

endpackage

@@ design/srtf_scheduler_unit.sv @@
// Top level of the shortest-remaining-time-first scheduler.
// Depends on srtf_pkg, srtf_ram and srtf_pick.
//
// Requests arrive on the req channel (req_valid, req_stall, req_data) and each
// produces exactly one response transaction on the rsp channel. An arrive
// transaction stores a job in the lowest free slot of the job table; a tick
// transaction picks the eligible job with the least remaining time, runs it
// for one time unit and advances the time by one.
// The job table sits in a RAM with a registered read. A tick reads every slot
// in turn, one per cycle, then a drain state lets the last read reach the
// selection unit before the commit. An arrive searches the valid bits one
// slot per cycle and stops at the first free slot; a zero-burst arrive
// skips the search and goes straight to the commit.
// One request is processed at a time; req_stall is high while it is in work.
// A finished response waits in an output register, so a new request can be
// accepted while rsp_stall holds the previous response. If that response is
// still stalled when the next one is ready, the block waits until it is taken.
// Reset clears the valid bits, the time, the order counter and the last
// running id; no clearing pass is needed.
module srtf_scheduler_unit
    import srtf_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int TIME_WIDTH  = DEFAULT_TIME_WIDTH
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req_data,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp_data
);

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W = JOB_W + TIME_WIDTH + BURST_W + ORDER_W;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_DEPTH - 1);

    state_t                 state_reg, state_next;
    req_item_t              item_reg, item_next;
    logic [IDX_W-1:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0]       slot_reg, slot_next;
    logic                   free_found_reg, free_found_next;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TIME_WIDTH-1:0]  time_reg, time_next;
    logic [ORDER_W-1:0]     order_reg, order_next;
    logic [LAST_W-1:0]      last_reg, last_next;
    logic                   rd_pend_reg, rd_pend_next;
    logic [IDX_W-1:0]       rd_slot_reg, rd_slot_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    rsp_item_t              rsp_data_reg, rsp_data_next;

    logic                   accept;
    logic                   commit_go;
    logic                   is_tick;
    logic                   zero_burst;
    logic [TIME_WIDTH-1:0]  time_inc;
    logic [BURST_W-1:0]     rem_dec;

    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [ENTRY_W-1:0]     ram_wdata;
    logic [ENTRY_W-1:0]     ram_rdata;

    pick_ctrl_t             pick_ctrl;
    logic                   pick_found;
    logic [IDX_W-1:0]       best_slot;
    logic [JOB_W-1:0]       best_job;
    logic [TIME_WIDTH-1:0]  best_arrival;
    logic [BURST_W-1:0]     best_remaining;
    logic [ORDER_W-1:0]     best_order;

    assign accept     = req_valid && !req_stall;
    assign commit_go  = (state_reg == ST_COMMIT) && (!rsp_valid_reg || !rsp_stall);
    assign is_tick    = (item_reg.kind == KIND_TICK);
    assign zero_burst = (item_reg.burst_length == '0);
    assign time_inc   = time_reg + 1'b1;
    assign rem_dec    = best_remaining - 1'b1;

    srtf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    srtf_pick #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .TIME_WIDTH  (TIME_WIDTH)
    ) u_pick (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (pick_ctrl),
        .slot           (rd_slot_reg),
        .slot_valid     (valid_reg[rd_slot_reg]),
        .now            (time_reg),
        .job            (ram_rdata[ENTRY_W-1 -: JOB_W]),
        .arrival        (ram_rdata[BURST_W+ORDER_W +: TIME_WIDTH]),
        .remaining      (ram_rdata[ORDER_W +: BURST_W]),
        .order          (ram_rdata[ORDER_W-1:0]),
        .found          (pick_found),
        .best_slot      (best_slot),
        .best_job       (best_job),
        .best_arrival   (best_arrival),
        .best_remaining (best_remaining),
        .best_order     (best_order)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_data.kind == KIND_TICK)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (req_data.burst_length == '0)
                    begin
                        state_next = ST_COMMIT;
                    end
                    else
                    begin
                        state_next = ST_FIND;
                    end
                end
            end
            ST_FIND:
            begin
                if (!valid_reg[cnt_reg] || (cnt_reg == LAST_SLOT))
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == LAST_SLOT)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (commit_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_stall        = (state_reg != ST_IDLE);
        pick_ctrl.clear  = accept;
        pick_ctrl.sample = rd_pend_reg;
        ram_we           = 1'b0;
        ram_waddr        = slot_reg;
        ram_wdata        = {item_reg.job_id, TIME_WIDTH'(item_reg.arrival_time),
                            item_reg.burst_length, order_reg};
        if (is_tick)
        begin
            ram_waddr = best_slot;
            ram_wdata = {best_job, best_arrival, rem_dec, best_order};
            ram_we    = commit_go && pick_found;
        end
        else
        begin
            ram_we = commit_go && !zero_burst && free_found_reg;
        end
    end

    always_comb
    begin
        item_next       = item_reg;
        cnt_next        = cnt_reg;
        slot_next       = slot_reg;
        free_found_next = free_found_reg;
        valid_next      = valid_reg;
        time_next       = time_reg;
        order_next      = order_reg;
        last_next       = last_reg;
        rd_pend_next    = 1'b0;
        rd_slot_next    = cnt_reg;
        rsp_valid_next  = rsp_valid_reg && rsp_stall;
        rsp_data_next   = rsp_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    item_next       = req_data;
                    cnt_next        = '0;
                    free_found_next = 1'b0;
                end
            end
            ST_FIND:
            begin
                if (!valid_reg[cnt_reg])
                begin
                    slot_next       = cnt_reg;
                    free_found_next = 1'b1;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_SCAN:
            begin
                rd_pend_next = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
            end
            ST_COMMIT:
            begin
                if (commit_go)
                begin
                    rsp_valid_next         = 1'b1;
                    rsp_data_next          = '0;
                    rsp_data_next.now_time = FIELD_W'(time_reg);
                    if (is_tick)
                    begin
                        time_next = time_inc;
                        if (pick_found)
                        begin
                            rsp_data_next.ran_valid = 1'b1;
                            rsp_data_next.ran_id    = best_job;
                            rsp_data_next.switched  = ({1'b0, best_job} != last_reg);
                            last_next               = {1'b0, best_job};
                            if (rem_dec == '0)
                            begin
                                rsp_data_next.finished    = 1'b1;
                                rsp_data_next.finish_time = FIELD_W'(time_inc);
                                valid_next[best_slot]     = 1'b0;
                            end
                        end
                    end
                    else if (zero_burst)
                    begin
                        rsp_data_next.status = STATUS_ZERO_BURST;
                    end
                    else if (free_found_reg)
                    begin
                        rsp_data_next.status = STATUS_OK;
                        valid_next[slot_reg] = 1'b1;
                        order_next           = order_reg + 1'b1;
                    end
                    else
                    begin
                        rsp_data_next.status = STATUS_FULL;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            time_reg       <= '0;
            order_reg      <= '0;
            last_reg       <= NONE_RUNNING;
            rd_pend_reg    <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            free_found_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            time_reg       <= time_next;
            order_reg      <= order_next;
            last_reg       <= last_next;
            rd_pend_reg    <= rd_pend_next;
            rsp_valid_reg  <= rsp_valid_next;
            free_found_reg <= free_found_next;
            cnt_reg        <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg     <= item_next;
        slot_reg     <= slot_next;
        rd_slot_reg  <= rd_slot_next;
        rsp_data_reg <= rsp_data_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    a_tick_advances_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        (commit_go && is_tick) |=> (time_reg == $past(time_reg) + 1'b1)
    ) else $error("Tick did not advance the time by one.");

    a_arrive_keeps_time: assert property (
        @(posedge clk) disable iff (!rst_n)
        (commit_go && !is_tick) |=> $stable(time_reg)
    ) else $error("Arrive changed the time.");

    a_finish_frees_slot: assert property (
        @(posedge clk) disable iff (!rst_n)
        (commit_go && is_tick && pick_found && (rem_dec == '0))
            |=> !valid_reg[$past(best_slot)]
    ) else $error("Finished job still holds its slot.");

    a_finish_needs_run: assert property (
        @(posedge clk) disable iff (!rst_n)
        rsp_valid_reg |-> (!rsp_data_reg.finished || rsp_data_reg.ran_valid)
    ) else $error("Completion reported without a running job.");

endmodule

@@ design/srtf_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module srtf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/srtf_pick.sv @@
// Selection unit that tracks the best eligible job while the table is streamed.
// Depends on srtf_pkg.
module srtf_pick
    import srtf_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH,
    parameter int TIME_WIDTH  = DEFAULT_TIME_WIDTH,
    localparam int IDX_W = $clog2(TABLE_DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pick_ctrl_t            ctrl,
    input  logic [IDX_W-1:0]      slot,
    input  logic                  slot_valid,
    input  logic [TIME_WIDTH-1:0] now,
    input  logic [JOB_W-1:0]      job,
    input  logic [TIME_WIDTH-1:0] arrival,
    input  logic [BURST_W-1:0]    remaining,
    input  logic [ORDER_W-1:0]    order,
    output logic                  found,
    output logic [IDX_W-1:0]      best_slot,
    output logic [JOB_W-1:0]      best_job,
    output logic [TIME_WIDTH-1:0] best_arrival,
    output logic [BURST_W-1:0]    best_remaining,
    output logic [ORDER_W-1:0]    best_order
);

    localparam int KEY_W = BURST_W + TIME_WIDTH + ORDER_W;

    logic                  found_reg, found_next;
    logic [IDX_W-1:0]      slot_reg;
    logic [JOB_W-1:0]      job_reg;
    logic [TIME_WIDTH-1:0] arrival_reg;
    logic [BURST_W-1:0]    remaining_reg;
    logic [ORDER_W-1:0]    order_reg;
    logic [KEY_W-1:0]      cand_key;
    logic [KEY_W-1:0]      best_key;
    logic                  take;

    assign cand_key = {remaining, arrival, order};
    assign best_key = {remaining_reg, arrival_reg, order_reg};

    always_comb
    begin
        take = ctrl.sample && slot_valid && (arrival <= now)
            && (!found_reg || (cand_key < best_key));
        if (ctrl.clear)
        begin
            found_next = 1'b0;
        end
        else
        begin
            found_next = found_reg || take;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else
        begin
            found_reg <= found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            slot_reg      <= slot;
            job_reg       <= job;
            arrival_reg   <= arrival;
            remaining_reg <= remaining;
            order_reg     <= order;
        end
    end

    assign found          = found_reg;
    assign best_slot      = slot_reg;
    assign best_job       = job_reg;
    assign best_arrival   = arrival_reg;
    assign best_remaining = remaining_reg;
    assign best_order     = order_reg;

endmodule
